// ===== src/bhs_pkg.sv =====
// Shared widths, types and result structures for the binary heap sort core.
`default_nettype none

package bhs_pkg;

	localparam int CAPACITY = 64;
	localparam int DW = 32;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CHW = AW + 2;

	typedef logic signed [DW-1:0] data_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [CHW-1:0] chld_t;

	typedef struct packed {
		data_t sorted_value;
		logic final_res;
		logic overflowed;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} push_t;

endpackage

`default_nettype wire

// ===== src/bhs_cmp.sv =====
// Shared signed compare unit: picks the larger of a candidate and the current maximum.
`default_nettype none

module bhs_cmp (
	input  wire bhs_pkg::data_t a,
	input  wire bhs_pkg::data_t b,
	input  wire                 en,
	output logic                take,
	output bhs_pkg::data_t      max_val
);

	assign take = en && (a > b);
	assign max_val = take ? a : b;

endmodule

`default_nettype wire

// ===== src/bhs_seq.sv =====
// Sequencer and element store: load, heap build, extraction and ordered readout.
`default_nettype none

module bhs_seq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire bhs_pkg::data_t  in_value,
	input  wire                  in_last,
	output bhs_pkg::push_t       push,
	input  wire                  push_ready
);

	typedef enum logic [8:0] {
		S_LOAD  = 9'b000000001,
		S_BREAD = 9'b000000010,
		S_BGET  = 9'b000000100,
		S_CMPL  = 9'b000001000,
		S_CMPR  = 9'b000010000,
		S_XREAD = 9'b000100000,
		S_XSWP  = 9'b001000000,
		S_ORD   = 9'b010000000,
		S_OEMIT = 9'b100000000
	} state_t;

	function automatic bhs_pkg::chld_t child_l(input bhs_pkg::addr_t n);
		child_l = {1'b0, n, 1'b1};
	endfunction

	state_t state_q, state_d;
	bhs_pkg::cnt_t count_q, count_d;
	logic drop_q, drop_d;
	logic build_q, build_d;
	bhs_pkg::addr_t k_q, k_d;
	bhs_pkg::addr_t node_q, node_d;
	bhs_pkg::cnt_t size_q, size_d;
	bhs_pkg::addr_t big_q, big_d;
	logic bnode_q, bnode_d;
	bhs_pkg::addr_t oidx_q, oidx_d;
	bhs_pkg::data_t sift_q, sift_d;
	bhs_pkg::data_t bval_q, bval_d;

	bhs_pkg::data_t mem [bhs_pkg::CAPACITY];
	bhs_pkg::data_t rda_q, rdb_q;

	logic we, rea, reb;
	bhs_pkg::addr_t wa, ra, rb;
	bhs_pkg::data_t wd;

	bhs_pkg::data_t cmp_a, cmp_b, cmp_max;
	logic cmp_en, take;

	bhs_pkg::chld_t lc, rc, nlc, nrc;
	logic lc_ok, rc_ok;
	bhs_pkg::addr_t nxt_node;
	logic full, is_final;
	bhs_pkg::cnt_t cnt_n;

	bhs_cmp u_cmp (
		.a      (cmp_a),
		.b      (cmp_b),
		.en     (cmp_en),
		.take   (take),
		.max_val(cmp_max)
	);

	assign lc = child_l(node_q);
	assign rc = lc + bhs_pkg::chld_t'(1);
	assign lc_ok = lc < bhs_pkg::chld_t'(size_q);
	assign rc_ok = rc < bhs_pkg::chld_t'(size_q);
	assign nxt_node = take ? rc[bhs_pkg::AW-1:0] : big_q;
	assign nlc = child_l(nxt_node);
	assign nrc = nlc + bhs_pkg::chld_t'(1);
	assign full = (count_q == bhs_pkg::cnt_t'(bhs_pkg::CAPACITY));
	assign cnt_n = full ? count_q : count_q + bhs_pkg::cnt_t'(1);
	assign is_final = (bhs_pkg::cnt_t'(oidx_q) + bhs_pkg::cnt_t'(1)) == count_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		drop_d = drop_q;
		build_d = build_q;
		k_d = k_q;
		node_d = node_q;
		size_d = size_q;
		big_d = big_q;
		bnode_d = bnode_q;
		oidx_d = oidx_q;
		sift_d = sift_q;
		bval_d = bval_q;
		we = 1'b0;
		wa = '0;
		wd = in_value;
		rea = 1'b0;
		ra = '0;
		reb = 1'b0;
		rb = '0;
		cmp_a = rda_q;
		cmp_b = sift_q;
		cmp_en = 1'b0;
		in_ready = 1'b0;
		push = '0;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!full) begin
						we = 1'b1;
						wa = count_q[bhs_pkg::AW-1:0];
						wd = in_value;
						count_d = cnt_n;
					end else begin
						drop_d = 1'b1;
					end
					if (in_last) begin
						if (cnt_n >= bhs_pkg::cnt_t'(2)) begin
							k_d = bhs_pkg::addr_t'(cnt_n >> 1);
							build_d = 1'b1;
							state_d = S_BREAD;
						end else begin
							oidx_d = '0;
							state_d = S_ORD;
						end
					end
				end
			end
			S_BREAD: begin
				node_d = k_q - bhs_pkg::addr_t'(1);
				size_d = count_q;
				rea = 1'b1;
				ra = k_q - bhs_pkg::addr_t'(1);
				state_d = S_BGET;
			end
			S_BGET: begin
				sift_d = rda_q;
				rea = 1'b1;
				ra = lc[bhs_pkg::AW-1:0];
				reb = 1'b1;
				rb = rc[bhs_pkg::AW-1:0];
				state_d = S_CMPL;
			end
			S_CMPL: begin
				cmp_a = rda_q;
				cmp_b = sift_q;
				cmp_en = lc_ok;
				if (take) begin
					big_d = lc[bhs_pkg::AW-1:0];
					bnode_d = 1'b0;
				end else begin
					bnode_d = 1'b1;
				end
				bval_d = cmp_max;
				state_d = S_CMPR;
			end
			S_CMPR: begin
				cmp_a = rdb_q;
				cmp_b = bval_q;
				cmp_en = rc_ok;
				we = 1'b1;
				wa = node_q;
				if (!take && bnode_q) begin
					// settle the sifted value and move to the next sift, or to the readout after the last
					wd = sift_q;
					if (build_q) begin
						if (k_q == bhs_pkg::addr_t'(1)) begin
							build_d = 1'b0;
							k_d = bhs_pkg::addr_t'(count_q - bhs_pkg::cnt_t'(1));
							state_d = S_XREAD;
						end else begin
							k_d = k_q - bhs_pkg::addr_t'(1);
							state_d = S_BREAD;
						end
					end else begin
						if (k_q == bhs_pkg::addr_t'(1)) begin
							oidx_d = '0;
							state_d = S_ORD;
						end else begin
							k_d = k_q - bhs_pkg::addr_t'(1);
							state_d = S_XREAD;
						end
					end
				end else begin
					// promote the larger child and descend
					wd = cmp_max;
					node_d = nxt_node;
					rea = 1'b1;
					ra = nlc[bhs_pkg::AW-1:0];
					reb = 1'b1;
					rb = nrc[bhs_pkg::AW-1:0];
					state_d = S_CMPL;
				end
			end
			S_XREAD: begin
				rea = 1'b1;
				ra = '0;
				reb = 1'b1;
				rb = k_q;
				state_d = S_XSWP;
			end
			S_XSWP: begin
				// park the root at the end, sift the old end value from the root
				we = 1'b1;
				wa = k_q;
				wd = rda_q;
				sift_d = rdb_q;
				node_d = '0;
				size_d = bhs_pkg::cnt_t'(k_q);
				rea = 1'b1;
				ra = bhs_pkg::addr_t'(1);
				reb = 1'b1;
				rb = bhs_pkg::addr_t'(2);
				state_d = S_CMPL;
			end
			S_ORD: begin
				rea = 1'b1;
				ra = oidx_q;
				state_d = S_OEMIT;
			end
			S_OEMIT: begin
				push.valid = 1'b1;
				push.res.sorted_value = rda_q;
				push.res.final_res = is_final;
				push.res.overflowed = drop_q;
				if (push_ready) begin
					if (is_final) begin
						count_d = '0;
						drop_d = 1'b0;
						state_d = S_LOAD;
					end else begin
						oidx_d = oidx_q + bhs_pkg::addr_t'(1);
						rea = 1'b1;
						ra = oidx_q + bhs_pkg::addr_t'(1);
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			drop_q <= 1'b0;
			build_q <= 1'b0;
			k_q <= '0;
			node_q <= '0;
			size_q <= '0;
			big_q <= '0;
			bnode_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			drop_q <= drop_d;
			build_q <= build_d;
			k_q <= k_d;
			node_q <= node_d;
			size_q <= size_d;
			big_q <= big_d;
			bnode_q <= bnode_d;
			oidx_q <= oidx_d;
		end
	end

	always_ff @(posedge clk) begin
		sift_q <= sift_d;
		bval_q <= bval_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rea) begin
			rda_q <= mem[ra];
		end
		if (reb) begin
			rdb_q <= mem[rb];
		end
	end

endmodule

`default_nettype wire

// ===== src/binary_heap_sort_core.sv =====
// Top level of the binary heap sort core: stream ports, output register, checks.
//
// Usage: send a set of signed 32-bit values on the s_ channel, one per request,
// with s_tlast on the final one. Up to 64 values are held; further values are
// dropped and every result of that set then carries m_tuser[0] = 1.
// While loading, s_tready stays high and a request is taken whenever s_tvalid
// is high. After the last request s_tready drops while one compare unit and a
// two-read, one-write store do the sort: each sift compares one level more
// than it descends (at most log2(n) + 1 levels), with n/2 sifts to build the
// heap and n-1 to extract it. Results then stream out ascending, one per cycle
// while m_tready allows, after a first read of the store, with m_tlast on the
// largest value. s_tready returns the cycle after the final result enters the
// output register, so a new set can load while it waits.
// A stall on m_tready holds the output register and pauses the readout.
// Reset clears the held count, the drop flag and the output valid; store
// contents are not cleared and are only read after being written.
`default_nettype none

module binary_heap_sort_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // [31:0] value
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,  // [31:0] sorted_value
	output logic        m_tlast,
	output logic [0:0]  m_tuser   // [0] overflowed
);

	bhs_pkg::push_t push;
	logic push_ready;
	bhs_pkg::res_t out_q;
	logic out_valid_q;

	bhs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (bhs_pkg::data_t'(s_tdata)),
		.in_last   (s_tlast),
		.push      (push),
		.push_ready(push_ready)
	);

	assign push_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid && push_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && push_ready) begin
			out_q <= push.res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = 32'(out_q.sorted_value);
	assign m_tlast = out_q.final_res;
	assign m_tuser = out_q.overflowed;

	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still ready after the last request of a set");

	a_no_push_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !push.valid)
		else $error("result pushed while loading");

	a_final_reopens_load: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push_ready && push.res.final_res |=> s_tready)
		else $error("input not ready after the final result of a set");

endmodule

`default_nettype wire

// ===== dv/tb_binary_heap_sort_core.sv =====
// Self-checking testbench for the binary heap sort core: sets of values in, sorted stream out.
`default_nettype none

module tb_binary_heap_sort_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // [31:0] value
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [31:0] sorted_value
	logic        m_tlast;
	logic [0:0]  m_tuser;        // [0] overflowed

	localparam bhs_pkg::data_t VAL_MAX = 32'sh7FFF_FFFF;
	localparam bhs_pkg::data_t VAL_MIN = 32'sh8000_0000;

	// predictor copy of the block's store
	bhs_pkg::data_t held_vals [bhs_pkg::CAPACITY];
	int    held_count = 0;
	logic  held_drop  = 1'b0;
	bhs_pkg::res_t sorted_q [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int errors = 0;

	binary_heap_sort_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void sift_held(int node, int size);
		int big;
		int lc;
		int rc;
		bhs_pkg::data_t t;
		forever begin
			big = node;
			lc = 2 * node + 1;
			rc = 2 * node + 2;
			if (lc < size && held_vals[lc] > held_vals[big])
				big = lc;
			if (rc < size && held_vals[rc] > held_vals[big])
				big = rc;
			if (big == node)
				return;
			t = held_vals[node];
			held_vals[node] = held_vals[big];
			held_vals[big] = t;
			node = big;
		end
	endfunction

	// Offer one request, wait for it to be taken, update the prediction.
	task automatic send_value(input bhs_pkg::data_t value, input logic is_last);
		int k;
		int gap;
		bhs_pkg::data_t t;
		bhs_pkg::res_t r;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		if (held_count < bhs_pkg::CAPACITY) begin
			held_vals[held_count] = value;
			held_count++;
		end else begin
			held_drop = 1'b1;
		end
		if (is_last) begin
			for (k = held_count / 2; k > 0; k--)
				sift_held(k - 1, held_count);
			for (k = held_count - 1; k > 0; k--) begin
				t = held_vals[0];
				held_vals[0] = held_vals[k];
				held_vals[k] = t;
				sift_held(0, k);
			end
			for (k = 0; k < held_count; k++) begin
				r.sorted_value = held_vals[k];
				r.final_res    = (k == held_count - 1);
				r.overflowed   = held_drop;
				sorted_q.push_back(r);
			end
			held_count = 0;
			held_drop  = 1'b0;
		end
		gap = 0;
		while (gap < 12 && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every predicted result has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sorted_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic bhs_pkg::data_t pick_value();
		case ($urandom_range(0, 9))
			0:       pick_value = VAL_MIN;
			1:       pick_value = VAL_MAX;
			2:       pick_value = '0;
			3:       pick_value = -32'sd1;
			4, 5:    pick_value = bhs_pkg::data_t'($urandom_range(0, 15)) - 32'sd8;
			default: pick_value = bhs_pkg::data_t'($urandom);
		endcase
	endfunction

	task automatic send_set(input int size);
		int k;
		for (k = 0; k < size; k++)
			send_value(pick_value(), k == size - 1);
	endtask

	task automatic test_edge_values();
		send_value(VAL_MAX, 1'b1);
		send_value(VAL_MIN, 1'b0);
		send_value(VAL_MAX, 1'b1);
		send_value(VAL_MAX, 1'b0);
		send_value(VAL_MIN, 1'b0);
		send_value(32'sd0, 1'b0);
		send_value(-32'sd1, 1'b0);
		send_value(32'sd1, 1'b0);
		send_value(-32'sd1, 1'b0);
		send_value(32'sd0, 1'b0);
		send_value(32'sh7FFF_FFFE, 1'b0);
		send_value(32'sh8000_0001, 1'b1);
		wait_drained();
	endtask

	// Exactly full store, last request still stored.
	task automatic test_full_set();
		send_set(bhs_pkg::CAPACITY);
		wait_drained();
	endtask

	// Two plain requests dropped, then a dropped last request that starts the sort.
	task automatic test_overflow();
		send_set(bhs_pkg::CAPACITY + 3);
		wait_drained();
	endtask

	task automatic test_random_sets(input int budget);
		int sent;
		int size;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 9) == 0)
				size = $urandom_range(13, 40);
			else
				size = $urandom_range(1, 12);
			send_set(size);
			sent += size;
			if ($urandom_range(0, 4) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	always @(posedge clk) begin : chk_result
		bhs_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_q.size() == 0) begin
				$error("unexpected result: sorted_value %0d", $signed(m_tdata));
				errors++;
			end else begin
				want = sorted_q.pop_front();
				if (m_tdata !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						want.sorted_value, $signed(m_tdata));
					errors++;
				end
				if (m_tlast !== want.final_res) begin
					$error("final_res: expected %0b, got %0b", want.final_res, m_tlast);
					errors++;
				end
				if (m_tuser[0] !== want.overflowed) begin
					$error("overflowed: expected %0b, got %0b", want.overflowed, m_tuser[0]);
					errors++;
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 32;
		rx_idle_pct = 48;
		test_edge_values();
		test_full_set();
		test_random_sets(85);

		tx_idle_pct = 48;
		rx_idle_pct = 32;
		test_overflow();
		test_random_sets(85);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_sets(85);

		wait_drained();
		repeat (32) @(posedge clk);
		if (errors == 0 && sorted_q.size() == 0)
			$display("binary_heap_sort_core verification clean");
		else
			$display("binary_heap_sort_core verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("binary_heap_sort_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire
